// ===== sv/tdn_pkg.sv =====
`timescale 1ns / 1ps

package tdn_pkg;

  localparam int CPU_W      = 10;
  localparam int CNT_W      = 7;
  localparam int ID_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic MODE_BLOCK  = 1'b0;
  localparam logic MODE_CYCLIC = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_HOSTS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MODE  = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_CLR  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_EV   = 8'b0001_0000,
    S_BRD  = 8'b0010_0000,
    S_BEV  = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load_start;
    logic load_step;
    logic run_start;
    logic clr_step;
    logic rd;
    logic ev_step;
    logic blk_start;
    logic brd;
    logic bev_emit;
    logic bev_next;
    logic err_emit;
    logic table_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic hosts_zero;
    logic tasks_zero;
    logic load_done;
    logic clr_done;
    logic take;
    logic run_done;
    logic blk_more;
    logic blk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/tdn_ifs.sv =====
`timescale 1ns / 1ps

interface tdn_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [tdn_pkg::CPU_W-1:0]  group_cpus;
  logic [tdn_pkg::CNT_W-1:0]  group_reps;

  modport source (output valid, output op, output group_cpus, output group_reps, input ready);
  modport sink   (input valid, input op, input group_cpus, input group_reps, output ready);
endinterface

interface tdn_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tdn_pkg::ID_W-1:0]   task_id;
  logic [tdn_pkg::ID_W-1:0]   host_id;
  logic [tdn_pkg::ID_W-1:0]   rank_on_host;
  logic                       status;
  logic                       last;

  modport source (output valid, output task_id, output host_id, output rank_on_host,
                  output status, output last, input ready);
  modport sink   (input valid, input task_id, input host_id, input rank_on_host,
                  input status, input last, output ready);
endinterface

interface tdn_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdn_pkg::CFG_IDX_W-1:0]   index;
  logic [tdn_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tdn_ctrl.sv =====
`timescale 1ns / 1ps

module tdn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_op_i,
  input  logic              dist_mode_i,
  input  tdn_pkg::dp_stat_t stat_i,
  output logic              req_ready_o,
  output tdn_pkg::dp_cmd_t  cmd_o
);
  import tdn_pkg::*;

  state_e state_q, state_d;
  logic   cyclic;

  assign cyclic      = (dist_mode_i == MODE_CYCLIC);
  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_op_i == OP_LOAD) begin
            cmd_o.load_start = 1'b1;
            state_d          = S_LOAD;
          end else if (stat_i.hosts_zero) begin
            state_d = S_ERR;
          end else if (stat_i.tasks_zero) begin
            cmd_o.table_clr = 1'b1;
          end else begin
            cmd_o.run_start = 1'b1;
            state_d         = S_CLR;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_step = 1'b1;
        if (stat_i.load_done) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        if (!(stat_i.take && cyclic && !stat_i.out_free)) begin
          cmd_o.ev_step = 1'b1;
          if (stat_i.take && stat_i.run_done) begin
            if (cyclic) begin
              cmd_o.table_clr = 1'b1;
              state_d         = S_IDLE;
            end else begin
              cmd_o.blk_start = 1'b1;
              state_d         = S_BRD;
            end
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_BRD: begin
        cmd_o.brd = 1'b1;
        state_d   = S_BEV;
      end
      S_BEV: begin
        if (stat_i.blk_more) begin
          if (stat_i.out_free) begin
            cmd_o.bev_emit = 1'b1;
            if (stat_i.blk_last) begin
              cmd_o.table_clr = 1'b1;
              state_d         = S_IDLE;
            end
          end
        end else begin
          cmd_o.bev_next = 1'b1;
          state_d        = S_BRD;
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.err_emit  = 1'b1;
          cmd_o.table_clr = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/tdn_datapath.sv =====
`timescale 1ns / 1ps

module tdn_datapath #(
  parameter int MAX_HOSTS = 64,
  parameter int MAX_TASKS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdn_pkg::dp_cmd_t             cmd_i,
  output tdn_pkg::dp_stat_t            stat_o,
  input  logic [tdn_pkg::CPU_W-1:0]    group_cpus_i,
  input  logic [tdn_pkg::CNT_W-1:0]    group_reps_i,
  input  logic [tdn_pkg::CNT_W-1:0]    host_count_i,
  input  logic [tdn_pkg::CNT_W-1:0]    task_count_i,
  input  logic                         dist_mode_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [tdn_pkg::ID_W-1:0]     task_id_o,
  output logic [tdn_pkg::ID_W-1:0]     host_id_o,
  output logic [tdn_pkg::ID_W-1:0]     rank_on_host_o,
  output logic                         status_o,
  output logic                         last_o
);
  import tdn_pkg::*;

  localparam int HW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CW = $clog2(MAX_HOSTS + 1);

  logic [CPU_W-1:0] cpus_mem  [MAX_HOSTS];
  logic [CNT_W-1:0] tally_mem [MAX_HOSTS];

  logic [CW-1:0]    ptr_q, h_q, hosts_w;
  logic [HW-1:0]    h_idx;
  logic [CNT_W-1:0] remain_q, round_q, placed_q, t_q, r_q, tasks_w;
  logic             over_q, room_q, out_valid_q;
  logic [CPU_W-1:0] cpus_q, cpus_rd_q, eff_cpus;
  logic [CNT_W-1:0] tally_rd_q;
  logic             inrng_q;
  logic             full, take, room_now, room_n, host_last, emit_cyc, emit;

  assign hosts_w = (32'(host_count_i) > MAX_HOSTS) ? CW'(MAX_HOSTS) : CW'(host_count_i);
  assign tasks_w = (32'(task_count_i) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : task_count_i;
  assign h_idx   = h_q[HW-1:0];
  assign full    = (ptr_q == CW'(MAX_HOSTS));

  assign eff_cpus  = inrng_q ? cpus_rd_q : '0;
  assign take      = (CPU_W'(round_q) < eff_cpus) || over_q;
  assign room_now  = (CPU_W'(round_q) + CPU_W'(1)) < eff_cpus;
  assign room_n    = room_q | (take & room_now);
  assign host_last = (h_q == hosts_w - CW'(1));

  assign emit_cyc = cmd_i.ev_step && take && (dist_mode_i == MODE_CYCLIC);
  assign emit     = emit_cyc || cmd_i.bev_emit || cmd_i.err_emit;

  always_comb begin
    stat_o            = '0;
    stat_o.hosts_zero = (hosts_w == '0);
    stat_o.tasks_zero = (tasks_w == '0);
    stat_o.load_done  = (remain_q == CNT_W'(1)) || full || (ptr_q == CW'(MAX_HOSTS - 1));
    stat_o.clr_done   = host_last;
    stat_o.take       = take;
    stat_o.run_done   = (placed_q + CNT_W'(1) == tasks_w);
    stat_o.blk_more   = (r_q < tally_rd_q);
    stat_o.blk_last   = (t_q + CNT_W'(1) == tasks_w);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      remain_q    <= '0;
      h_q         <= '0;
      round_q     <= '0;
      placed_q    <= '0;
      over_q      <= 1'b0;
      room_q      <= 1'b0;
      t_q         <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_start) begin
        remain_q <= (group_reps_i == '0) ? CNT_W'(1) : group_reps_i;
      end
      if (cmd_i.load_step) begin
        remain_q <= remain_q - CNT_W'(1);
        if (!full) begin
          ptr_q <= ptr_q + CW'(1);
        end
      end
      if (cmd_i.table_clr) begin
        ptr_q <= '0;
      end
      if (cmd_i.run_start) begin
        h_q <= '0;
      end
      if (cmd_i.clr_step) begin
        if (host_last) begin
          h_q      <= '0;
          round_q  <= '0;
          placed_q <= '0;
          over_q   <= 1'b0;
          room_q   <= 1'b0;
        end else begin
          h_q <= h_q + CW'(1);
        end
      end
      if (cmd_i.ev_step) begin
        if (take) begin
          placed_q <= placed_q + CNT_W'(1);
        end
        if (cmd_i.blk_start) begin
          h_q <= '0;
          t_q <= '0;
        end else if (host_last) begin
          h_q     <= '0;
          round_q <= round_q + CNT_W'(1);
          over_q  <= over_q | !room_n;
          room_q  <= 1'b0;
        end else begin
          h_q    <= h_q + CW'(1);
          room_q <= room_n;
        end
      end
      if (cmd_i.brd) begin
        r_q <= '0;
      end
      if (cmd_i.bev_emit) begin
        r_q <= r_q + CNT_W'(1);
        t_q <= t_q + CNT_W'(1);
      end
      if (cmd_i.bev_next) begin
        h_q <= h_q + CW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // CPU table: entries at or above the fill pointer read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      cpus_q <= group_cpus_i;
    end
    if (cmd_i.load_step && !full) begin
      cpus_mem[ptr_q[HW-1:0]] <= cpus_q;
    end
    if (cmd_i.rd) begin
      cpus_rd_q <= cpus_mem[h_idx];
      inrng_q   <= (h_q < ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      tally_mem[h_idx] <= '0;
    end else if (cmd_i.ev_step && take) begin
      tally_mem[h_idx] <= tally_rd_q + CNT_W'(1);
    end
    if (cmd_i.rd || cmd_i.brd) begin
      tally_rd_q <= tally_mem[h_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cmd_i.err_emit) begin
        task_id_o      <= '0;
        host_id_o      <= '0;
        rank_on_host_o <= '0;
        status_o       <= STATUS_NO_HOSTS;
        last_o         <= 1'b1;
      end else if (cmd_i.bev_emit) begin
        task_id_o      <= ID_W'(t_q);
        host_id_o      <= ID_W'(h_q);
        rank_on_host_o <= ID_W'(r_q);
        status_o       <= STATUS_OK;
        last_o         <= stat_o.blk_last;
      end else begin
        task_id_o      <= ID_W'(placed_q);
        host_id_o      <= ID_W'(h_q);
        rank_on_host_o <= ID_W'(tally_rd_q);
        status_o       <= STATUS_OK;
        last_o         <= stat_o.run_done;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");

  a_placed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ev_step && take) |-> (placed_q < tasks_w))
    else $error("more tasks placed than requested");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bev_emit |-> (r_q < tally_rd_q))
    else $error("block rank beyond host tally");

  a_host_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd || cmd_i.brd || cmd_i.clr_step) |-> (h_q < hosts_w))
    else $error("host index beyond host count");
`endif

endmodule

// ===== sv/task_to_node_distributor_unit.sv =====
`timescale 1ns / 1ps

// Task-to-host distributor.
// req_i carries commands: op load writes group_cpus into the next group_reps
// entries of the host CPU table (zero reps counts as one); op run lays out
// task_count tasks over host_count hosts and clears the table afterwards.
// cfg_i (always ready) writes host_count, task_count and dist_mode (0 block,
// 1 cyclic); the user must write it only while the unit is idle (not enforced).
// rsp_o gives one transaction per placed task (task, host, rank, last), or a
// single status transaction with last set when host_count is zero.
// A load drops req_i.ready after the accept while it writes one table entry
// per cycle, until group_reps entries are written or the table fills.
// A run first clears the tally of each of the host_count hosts, then deals
// with a read and an evaluate state per host visit (the CPU table read is
// registered); block mode adds a numbering walk over hosts and tasks.
// One result register decouples rsp_o: when the receiver stalls, the dealing
// or numbering walk waits at the next result until the register frees.
// After reset the table is empty, host_count and task_count are 1 and the
// mode is block; no clearing pass is needed.
module task_to_node_distributor_unit #(
  parameter int MAX_HOSTS = 64,
  parameter int MAX_TASKS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdn_req_if.sink   req_i,
  tdn_cfg_if.sink   cfg_i,
  tdn_rsp_if.source rsp_o
);
  import tdn_pkg::*;

  logic [CNT_W-1:0] host_count_q, task_count_q;
  logic             dist_mode_q;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_count_q <= CNT_W'(1);
      task_count_q <= CNT_W'(1);
      dist_mode_q  <= MODE_BLOCK;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_HOST_COUNT: host_count_q <= cfg_i.data;
        CFG_TASK_COUNT: task_count_q <= cfg_i.data;
        CFG_DIST_MODE:  dist_mode_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  tdn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .dist_mode_i (dist_mode_q),
    .stat_i      (stat),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  tdn_datapath #(
    .MAX_HOSTS (MAX_HOSTS),
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .group_cpus_i   (req_i.group_cpus),
    .group_reps_i   (req_i.group_reps),
    .host_count_i   (host_count_q),
    .task_count_i   (task_count_q),
    .dist_mode_i    (dist_mode_q),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .task_id_o      (rsp_o.task_id),
    .host_id_o      (rsp_o.host_id),
    .rank_on_host_o (rsp_o.rank_on_host),
    .status_o       (rsp_o.status),
    .last_o         (rsp_o.last)
  );

endmodule
